FILE: src/qtsm_pkg.sv
// ----------------------------------------------------------------------------
// qtsm_pkg
// Shared widths, constants, pipeline word types and small arithmetic helpers
// for the quad torque saturation and mixing pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qtsm_pkg;

	localparam int FRAC_BITS = 14;

	localparam int TORQUE_W = 16;
	localparam int DUTY_W   = 15;
	localparam int MAG_W    = TORQUE_W;
	// Sum of three magnitudes: two up to 2^15 and a yaw term up to one.
	localparam int SUM_W    = TORQUE_W + 1;
	// min(thrust, 1 - thrust) never exceeds one half.
	localparam int LIM_W    = FRAC_BITS;
	localparam int PROD_W   = MAG_W + LIM_W - 1;
	localparam int QUO_W    = LIM_W;
	localparam int MIX_W    = TORQUE_W + 3;
	localparam int NUM_AX   = 3;

	localparam int AX_ROLL  = 0;
	localparam int AX_PITCH = 1;
	localparam int AX_YAW   = 2;

	localparam logic [DUTY_W-1:0] ONE_Q           = DUTY_W'(1 << FRAC_BITS);
	localparam logic [DUTY_W-1:0] YAW_LIMIT_RESET = DUTY_W'(1311);

	typedef struct packed {
		logic [NUM_AX-1:0]            neg;
		logic [NUM_AX-1:0][MAG_W-1:0] mag;
		logic [DUTY_W-1:0]            thr;
		logic [LIM_W-1:0]             lim;
	} prep_t;

	typedef struct packed {
		logic [NUM_AX-1:0][SUM_W-1:0] rem;
		logic [NUM_AX-1:0][QUO_W-1:0] quo;
		logic [NUM_AX-1:0]            neg;
		logic [NUM_AX-1:0][MAG_W-1:0] mag;
		logic [DUTY_W-1:0]            thr;
		logic                         scaled;
		logic [SUM_W-1:0]             sum;
	} div_t;

	function automatic logic [MAG_W-1:0] mag_of(input logic signed [TORQUE_W:0] v);
		logic signed [TORQUE_W:0] a;
		a = v[TORQUE_W] ? -v : v;
		return a[MAG_W-1:0];
	endfunction

	function automatic logic signed [MAG_W:0] apply_sign(input logic neg,
			input logic [MAG_W-1:0] m);
		logic signed [MAG_W:0] e;
		e = $signed({1'b0, m});
		return neg ? -e : e;
	endfunction

	function automatic logic [DUTY_W-1:0] sat_duty(input logic signed [MIX_W-1:0] v);
		logic signed [MIX_W-1:0] one_e;
		one_e = $signed({{(MIX_W-DUTY_W){1'b0}}, ONE_Q});
		if (v < 0) begin
			return '0;
		end else if (v > one_e) begin
			return ONE_Q;
		end else begin
			return v[DUTY_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

FILE: src/quad_torque_saturate_and_mix.sv
// An input word passes the prep, product, QUO_W divider and mix registers.
// Throughput: one word per cycle while out_stall is low. The divider has QUO_W
// restoring stages, one quotient bit per stage for all three axes in parallel.
// Each stage advances when it is empty or the next stage advances, so
// bubbles close up while the output is stalled.
// Reset clears all valid bits and loads the yaw limit with 1311 (0.08).
// ----------------------------------------------------------------------------
// quad_torque_saturate_and_mix
// Quadcopter X-frame mixer: clamps yaw, scales the torques into the thrust
// budget and mixes four saturated motor duties.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_torque_saturate_and_mix import qtsm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [TORQUE_W-1:0] roll_torque,
	input  logic signed [TORQUE_W-1:0] pitch_torque,
	input  logic signed [TORQUE_W-1:0] yaw_torque,
	input  logic        [DUTY_W-1:0]   thrust,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [TORQUE_W-1:0] roll_out,
	output logic signed [TORQUE_W-1:0] pitch_out,
	output logic signed [TORQUE_W-1:0] yaw_out,
	output logic        [DUTY_W-1:0]   motor_a,
	output logic        [DUTY_W-1:0]   motor_b,
	output logic        [DUTY_W-1:0]   motor_c,
	output logic        [DUTY_W-1:0]   motor_d,
	output logic                       was_scaled,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic        [DUTY_W-1:0]   cfg_data
);

	logic [DUTY_W-1:0] yaw_limit_q;

	logic  v_s1, v_s2;
	prep_t prep_s1;
	div_t  div_s2;
	logic  en_s1, en_s2, en_out;

	logic [QUO_W-1:0] v_s3;
	logic [QUO_W-1:0] en_s3;
	div_t             div_s3 [QUO_W];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_limit_q <= YAW_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			yaw_limit_q <= cfg_data;
		end
	end

	// Enable chain: a stage loads when it holds nothing or its word moves on.
	assign en_out = !out_valid || !out_stall;
	always_comb begin
		en_s3[QUO_W-1] = !v_s3[QUO_W-1] || en_out;
		for (int k = QUO_W - 2; k >= 0; k--) begin
			en_s3[k] = !v_s3[k] || en_s3[k+1];
		end
	end
	assign en_s2    = !v_s2 || en_s3[0];
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	qtsm_prep u_prep (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en_s1),
		.in_valid     (in_valid),
		.roll_torque  (roll_torque),
		.pitch_torque (pitch_torque),
		.yaw_torque   (yaw_torque),
		.thrust       (thrust),
		.yaw_limit    (yaw_limit_q),
		.v_s1         (v_s1),
		.prep_s1      (prep_s1)
	);

	qtsm_prod u_prod (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en_s2),
		.v_s1    (v_s1),
		.prep_s1 (prep_s1),
		.v_s2    (v_s2),
		.div_s2  (div_s2)
	);

	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		if (k == 0) begin : g_first
			qtsm_div_stage u_stage (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en_s3[k]),
				.v_in   (v_s2),
				.div_in (div_s2),
				.v_s3   (v_s3[k]),
				.div_s3 (div_s3[k])
			);
		end else begin : g_next
			qtsm_div_stage u_stage (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en_s3[k]),
				.v_in   (v_s3[k-1]),
				.div_in (div_s3[k-1]),
				.v_s3   (v_s3[k]),
				.div_s3 (div_s3[k])
			);
		end
	end

	qtsm_mix u_mix (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en_out),
		.v_in       (v_s3[QUO_W-1]),
		.div_in     (div_s3[QUO_W-1]),
		.out_valid  (out_valid),
		.roll_out   (roll_out),
		.pitch_out  (pitch_out),
		.yaw_out    (yaw_out),
		.motor_a    (motor_a),
		.motor_b    (motor_b),
		.motor_c    (motor_c),
		.motor_d    (motor_d),
		.was_scaled (was_scaled)
	);

endmodule

`default_nettype wire

FILE: src/qtsm_prep.sv
// ----------------------------------------------------------------------------
// qtsm_prep
// First stage: saturates thrust and yaw limit, clamps yaw, takes magnitudes
// and signs and forms the torque budget min(thrust, 1 - thrust).
// ----------------------------------------------------------------------------
`default_nettype none

module qtsm_prep import qtsm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic signed [TORQUE_W-1:0] roll_torque,
	input  logic signed [TORQUE_W-1:0] pitch_torque,
	input  logic signed [TORQUE_W-1:0] yaw_torque,
	input  logic        [DUTY_W-1:0]   thrust,
	input  logic        [DUTY_W-1:0]   yaw_limit,
	output logic                       v_s1,
	output prep_t                      prep_s1
);

	logic        [DUTY_W-1:0] thr_sat;
	logic        [DUTY_W-1:0] ylim_sat;
	logic        [DUTY_W-1:0] one_minus;
	logic signed [TORQUE_W:0] yaw_ext;
	logic signed [TORQUE_W:0] ylim_pos;
	logic signed [TORQUE_W:0] ylim_neg;
	logic signed [TORQUE_W:0] yaw_clamp;
	prep_t                    prep_d;

	always_comb begin
		thr_sat   = (thrust > ONE_Q) ? ONE_Q : thrust;
		ylim_sat  = (yaw_limit > ONE_Q) ? ONE_Q : yaw_limit;
		one_minus = ONE_Q - thr_sat;

		yaw_ext  = $signed({yaw_torque[TORQUE_W-1], yaw_torque});
		ylim_pos = $signed({{(TORQUE_W+1-DUTY_W){1'b0}}, ylim_sat});
		ylim_neg = -ylim_pos;
		if (yaw_ext > ylim_pos) begin
			yaw_clamp = ylim_pos;
		end else if (yaw_ext < ylim_neg) begin
			yaw_clamp = ylim_neg;
		end else begin
			yaw_clamp = yaw_ext;
		end

		prep_d.neg[AX_ROLL]  = roll_torque[TORQUE_W-1];
		prep_d.neg[AX_PITCH] = pitch_torque[TORQUE_W-1];
		prep_d.neg[AX_YAW]   = yaw_clamp[TORQUE_W];
		prep_d.mag[AX_ROLL]  = mag_of($signed({roll_torque[TORQUE_W-1], roll_torque}));
		prep_d.mag[AX_PITCH] = mag_of($signed({pitch_torque[TORQUE_W-1], pitch_torque}));
		prep_d.mag[AX_YAW]   = mag_of(yaw_clamp);
		prep_d.thr           = thr_sat;
		prep_d.lim           = (one_minus < thr_sat) ? one_minus[LIM_W-1:0]
		                                             : thr_sat[LIM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_s1 <= prep_d;
		end
	end

endmodule

`default_nettype wire

FILE: src/qtsm_prod.sv
// ----------------------------------------------------------------------------
// qtsm_prod
// Second stage: sums the magnitudes, decides whether scaling is needed and
// forms each magnitude times the budget as the dividend for the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module qtsm_prod import qtsm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  v_s1,
	input  prep_t prep_s1,
	output logic  v_s2,
	output div_t  div_s2
);

	logic [NUM_AX-1:0][MAG_W+LIM_W-1:0] prod;
	logic [SUM_W-1:0]                   sum;
	div_t                               div_d;

	always_comb begin
		sum = SUM_W'(prep_s1.mag[AX_ROLL]) + SUM_W'(prep_s1.mag[AX_PITCH])
		    + SUM_W'(prep_s1.mag[AX_YAW]);
		div_d.neg    = prep_s1.neg;
		div_d.mag    = prep_s1.mag;
		div_d.thr    = prep_s1.thr;
		div_d.sum    = sum;
		div_d.scaled = sum > SUM_W'(prep_s1.lim);
		for (int i = 0; i < NUM_AX; i++) begin
			prod[i] = (MAG_W+LIM_W)'(prep_s1.mag[i]) * (MAG_W+LIM_W)'(prep_s1.lim);
			// The high part starts as the partial remainder, the low part is
			// shifted in one bit per divider stage.
			div_d.rem[i] = SUM_W'(prod[i][PROD_W-1:QUO_W]);
			div_d.quo[i] = prod[i][QUO_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s2 <= div_d;
		end
	end

endmodule

`default_nettype wire

FILE: src/qtsm_div_stage.sv
// ----------------------------------------------------------------------------
// qtsm_div_stage
// One restoring division step for the three axes: yields one quotient bit
// per axis and carries the rest of the word along.
// ----------------------------------------------------------------------------
`default_nettype none

module qtsm_div_stage import qtsm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  div_t div_in,
	output logic v_s3,
	output div_t div_s3
);

	logic [NUM_AX-1:0][SUM_W:0] sh;
	logic [NUM_AX-1:0][SUM_W:0] diff;
	logic [NUM_AX-1:0]          ge;
	div_t                       div_d;

	always_comb begin
		div_d = div_in;
		for (int i = 0; i < NUM_AX; i++) begin
			sh[i]   = {div_in.rem[i], div_in.quo[i][QUO_W-1]};
			diff[i] = sh[i] - {1'b0, div_in.sum};
			ge[i]   = sh[i] >= {1'b0, div_in.sum};
			div_d.rem[i] = ge[i] ? diff[i][SUM_W-1:0] : sh[i][SUM_W-1:0];
			div_d.quo[i] = {div_in.quo[i][QUO_W-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s3 <= div_d;
		end
	end

endmodule

`default_nettype wire

FILE: src/qtsm_mix.sv
// ----------------------------------------------------------------------------
// qtsm_mix
// Output stage: picks scaled or plain torques, restores signs, mixes the
// four X-frame motor duties with saturation and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module qtsm_mix import qtsm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       v_in,
	input  div_t                       div_in,
	output logic                       out_valid,
	output logic signed [TORQUE_W-1:0] roll_out,
	output logic signed [TORQUE_W-1:0] pitch_out,
	output logic signed [TORQUE_W-1:0] yaw_out,
	output logic        [DUTY_W-1:0]   motor_a,
	output logic        [DUTY_W-1:0]   motor_b,
	output logic        [DUTY_W-1:0]   motor_c,
	output logic        [DUTY_W-1:0]   motor_d,
	output logic                       was_scaled
);

	logic [NUM_AX-1:0][MAG_W-1:0] m;
	logic signed [MAG_W:0]        r_v, p_v, y_v;
	logic signed [MIX_W-1:0]      t_e, r_e, p_e, y_e;

	logic                       v_s4;
	logic signed [TORQUE_W-1:0] roll_s4, pitch_s4, yaw_s4;
	logic        [DUTY_W-1:0]   ma_s4, mb_s4, mc_s4, md_s4;
	logic                       scaled_s4;

	always_comb begin
		for (int i = 0; i < NUM_AX; i++) begin
			m[i] = div_in.scaled ? MAG_W'(div_in.quo[i]) : div_in.mag[i];
		end
		r_v = apply_sign(div_in.neg[AX_ROLL], m[AX_ROLL]);
		p_v = apply_sign(div_in.neg[AX_PITCH], m[AX_PITCH]);
		y_v = apply_sign(div_in.neg[AX_YAW], m[AX_YAW]);
		t_e = $signed({{(MIX_W-DUTY_W){1'b0}}, div_in.thr});
		r_e = MIX_W'(r_v);
		p_e = MIX_W'(p_v);
		y_e = MIX_W'(y_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_s4   <= r_v[TORQUE_W-1:0];
			pitch_s4  <= p_v[TORQUE_W-1:0];
			yaw_s4    <= y_v[TORQUE_W-1:0];
			ma_s4     <= sat_duty(t_e + r_e + p_e - y_e);
			mb_s4     <= sat_duty(t_e + r_e - p_e + y_e);
			mc_s4     <= sat_duty(t_e - r_e + p_e + y_e);
			md_s4     <= sat_duty(t_e - r_e - p_e - y_e);
			scaled_s4 <= div_in.scaled;
		end
	end

	assign out_valid  = v_s4;
	assign roll_out   = roll_s4;
	assign pitch_out  = pitch_s4;
	assign yaw_out    = yaw_s4;
	assign motor_a    = ma_s4;
	assign motor_b    = mb_s4;
	assign motor_c    = mc_s4;
	assign motor_d    = md_s4;
	assign was_scaled = scaled_s4;

endmodule

`default_nettype wire

FILE: src/qtsm_checker.sv
// ----------------------------------------------------------------------------
// qtsm_checker
// Port-level checks for the mixer: output word holding, stall coupling and
// result ranges. Bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module qtsm_checker import qtsm_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic signed [TORQUE_W-1:0] roll_out,
	input logic signed [TORQUE_W-1:0] pitch_out,
	input logic signed [TORQUE_W-1:0] yaw_out,
	input logic        [DUTY_W-1:0]   motor_a,
	input logic        [DUTY_W-1:0]   motor_b,
	input logic        [DUTY_W-1:0]   motor_c,
	input logic        [DUTY_W-1:0]   motor_d,
	input logic                       was_scaled
);

	localparam logic signed [TORQUE_W-1:0] HI_T = TORQUE_W'(1 << FRAC_BITS);
	localparam logic signed [TORQUE_W-1:0] LO_T = -HI_T;

	// A stalled output word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid
			&& $stable({roll_out, pitch_out, yaw_out, motor_a, motor_b,
				motor_c, motor_d, was_scaled}))
		else $error("output word changed while stalled");

	// The input side only backs up when the output side is held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || !out_stall) |-> !in_stall)
		else $error("input stalled while output can move");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> motor_a <= ONE_Q && motor_b <= ONE_Q
			&& motor_c <= ONE_Q && motor_d <= ONE_Q)
		else $error("motor duty above one");

	a_torque_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> roll_out >= LO_T && roll_out <= HI_T
			&& pitch_out >= LO_T && pitch_out <= HI_T
			&& yaw_out >= LO_T && yaw_out <= HI_T)
		else $error("torque output out of range");

endmodule

bind quad_torque_saturate_and_mix qtsm_checker u_qtsm_checker (.*);

`default_nettype wire

FILE: verif/quad_mix_checker.sv
// ----------------------------------------------------------------------------
// quad_mix_checker
// Watches the command, result and yaw limit channels of the quad torque
// mixer, predicts each result word from the accepted command word and the
// current yaw limit, and compares the two field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_mix_checker import qtsm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic signed [TORQUE_W-1:0] roll_torque,
	input  logic signed [TORQUE_W-1:0] pitch_torque,
	input  logic signed [TORQUE_W-1:0] yaw_torque,
	input  logic        [DUTY_W-1:0]   thrust,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic signed [TORQUE_W-1:0] roll_out,
	input  logic signed [TORQUE_W-1:0] pitch_out,
	input  logic signed [TORQUE_W-1:0] yaw_out,
	input  logic        [DUTY_W-1:0]   motor_a,
	input  logic        [DUTY_W-1:0]   motor_b,
	input  logic        [DUTY_W-1:0]   motor_c,
	input  logic        [DUTY_W-1:0]   motor_d,
	input  logic                       was_scaled,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic        [DUTY_W-1:0]   cfg_data,
	output int                         fail_count,
	output int                         words_pending
);

	localparam longint UNITY = longint'(1) << FRAC_BITS;

	typedef struct packed {
		logic [TORQUE_W-1:0] roll;
		logic [TORQUE_W-1:0] pitch;
		logic [TORQUE_W-1:0] yaw;
		logic [DUTY_W-1:0]   duty_a;
		logic [DUTY_W-1:0]   duty_b;
		logic [DUTY_W-1:0]   duty_c;
		logic [DUTY_W-1:0]   duty_d;
		logic                scaled;
	} mix_word_t;

	mix_word_t         mix_expect_q[$];
	logic [DUTY_W-1:0] yaw_limit_copy = YAW_LIMIT_RESET;

	initial fail_count = 0;
	initial words_pending = 0;

	function automatic longint magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Magnitude times budget over total, truncated toward zero, sign restored.
	function automatic longint shrink(input longint v, input longint budget,
			input longint total);
		longint m;
		m = (magnitude(v) * budget) / total;
		return (v < 0) ? -m : m;
	endfunction

	function automatic logic [DUTY_W-1:0] duty_clip(input longint v);
		longint c;
		c = v;
		if (c < 0) begin
			c = 0;
		end
		if (c > UNITY) begin
			c = UNITY;
		end
		return c[DUTY_W-1:0];
	endfunction

	function automatic mix_word_t predict_mix(input logic signed [TORQUE_W-1:0] r_in,
			input logic signed [TORQUE_W-1:0] p_in, input logic signed [TORQUE_W-1:0] y_in,
			input logic [DUTY_W-1:0] t_in, input logic [DUTY_W-1:0] lim_in);
		longint    r, p, y, t, yl, total, budget;
		mix_word_t w;
		r = longint'(r_in);
		p = longint'(p_in);
		y = longint'(y_in);
		t = longint'(t_in);
		yl = longint'(lim_in);
		if (t > UNITY) begin
			t = UNITY;
		end
		if (yl > UNITY) begin
			yl = UNITY;
		end
		if (y > yl) begin
			y = yl;
		end
		if (y < -yl) begin
			y = -yl;
		end
		total = magnitude(r) + magnitude(p) + magnitude(y);
		budget = (UNITY - t < t) ? UNITY - t : t;
		w.scaled = (total > budget);
		if (w.scaled) begin
			r = shrink(r, budget, total);
			p = shrink(p, budget, total);
			y = shrink(y, budget, total);
		end
		w.roll   = r[TORQUE_W-1:0];
		w.pitch  = p[TORQUE_W-1:0];
		w.yaw    = y[TORQUE_W-1:0];
		w.duty_a = duty_clip(t + r + p - y);
		w.duty_b = duty_clip(t + r - p + y);
		w.duty_c = duty_clip(t - r + p + y);
		w.duty_d = duty_clip(t - r - p - y);
		return w;
	endfunction

	task automatic check_field(input string field, input longint expd, input longint got);
		if (expd != got) begin
			$error("%s: expected %0d, got %0d", field, expd, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mix_word_t w;
		if (!arst_n) begin
			mix_expect_q.delete();
			yaw_limit_copy = YAW_LIMIT_RESET;
			words_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				yaw_limit_copy = cfg_data;
			end
			// The result side is checked before this edge's command is queued,
			// so that a word with nothing waiting is never matched to it.
			if (out_valid && !out_stall) begin
				if (mix_expect_q.size() == 0) begin
					$error("result word with no command outstanding");
					fail_count++;
				end else begin
					w = mix_expect_q.pop_front();
					check_field("roll_out", longint'($signed(w.roll)), longint'(roll_out));
					check_field("pitch_out", longint'($signed(w.pitch)),
						longint'(pitch_out));
					check_field("yaw_out", longint'($signed(w.yaw)), longint'(yaw_out));
					check_field("motor_a", longint'(w.duty_a), longint'(motor_a));
					check_field("motor_b", longint'(w.duty_b), longint'(motor_b));
					check_field("motor_c", longint'(w.duty_c), longint'(motor_c));
					check_field("motor_d", longint'(w.duty_d), longint'(motor_d));
					check_field("was_scaled", longint'(w.scaled), longint'(was_scaled));
				end
			end
			if (in_valid && !in_stall) begin
				mix_expect_q.push_back(predict_mix(roll_torque, pitch_torque, yaw_torque,
					thrust, yaw_limit_copy));
			end
			words_pending <= mix_expect_q.size();
		end
	end

endmodule

`default_nettype wire

FILE: verif/quad_torque_saturate_and_mix_tb.sv
// ----------------------------------------------------------------------------
// quad_torque_saturate_and_mix_tb
// Drives directed and random torque commands through the mixer under several
// yaw limits, with random idling on both channels, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_torque_saturate_and_mix_tb import qtsm_pkg::*;;

	localparam int PHASES    = 8;
	localparam int PHASE_LEN = 181;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [TORQUE_W-1:0] roll_torque = '0;
	logic signed [TORQUE_W-1:0] pitch_torque = '0;
	logic signed [TORQUE_W-1:0] yaw_torque = '0;
	logic        [DUTY_W-1:0]   thrust = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [TORQUE_W-1:0] roll_out;
	logic signed [TORQUE_W-1:0] pitch_out;
	logic signed [TORQUE_W-1:0] yaw_out;
	logic        [DUTY_W-1:0]   motor_a;
	logic        [DUTY_W-1:0]   motor_b;
	logic        [DUTY_W-1:0]   motor_c;
	logic        [DUTY_W-1:0]   motor_d;
	logic                       was_scaled;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic        [DUTY_W-1:0]   cfg_data = '0;
	int                         fail_count;
	int                         words_pending;
	bit                         calm = 1'b0;

	quad_torque_saturate_and_mix dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.roll_torque  (roll_torque),
		.pitch_torque (pitch_torque),
		.yaw_torque   (yaw_torque),
		.thrust       (thrust),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.roll_out     (roll_out),
		.pitch_out    (pitch_out),
		.yaw_out      (yaw_out),
		.motor_a      (motor_a),
		.motor_b      (motor_b),
		.motor_c      (motor_c),
		.motor_d      (motor_d),
		.was_scaled   (was_scaled),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	quad_mix_checker mix_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.roll_torque   (roll_torque),
		.pitch_torque  (pitch_torque),
		.yaw_torque    (yaw_torque),
		.thrust        (thrust),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.roll_out      (roll_out),
		.pitch_out     (pitch_out),
		.yaw_out       (yaw_out),
		.motor_a       (motor_a),
		.motor_b       (motor_b),
		.motor_c       (motor_c),
		.motor_d       (motor_d),
		.was_scaled    (was_scaled),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.words_pending (words_pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Result side back-pressure in random bursts, switched off for the calm tail.
	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic signed [TORQUE_W-1:0] pick_torque();
		logic signed [TORQUE_W-1:0] v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 5))
					0: v = -16'sd32768;
					1: v = 16'sd32767;
					2: v = 16'sd0;
					3: v = -16'sd1;
					4: v = 16'sd16384;
					default: v = -16'sd16384;
				endcase
			end
			1, 2, 3, 4: begin
				// Mostly inside the thrust budget, so the unscaled path is well used.
				v = TORQUE_W'($urandom_range(0, 4000));
				if ($urandom_range(0, 1)) begin
					v = -v;
				end
			end
			default: v = TORQUE_W'($urandom);
		endcase
		return v;
	endfunction

	function automatic logic [DUTY_W-1:0] pick_thrust();
		logic [DUTY_W-1:0] v;
		case ($urandom_range(0, 9))
			8: begin
				case ($urandom_range(0, 3))
					0: v = '0;
					1: v = 15'd16384;
					2: v = 15'd8192;
					default: v = 15'd1;
				endcase
			end
			9: v = DUTY_W'($urandom_range(16385, 32767));
			default: v = DUTY_W'($urandom_range(0, 16384));
		endcase
		return v;
	endfunction

	task automatic send_command(input logic signed [TORQUE_W-1:0] r,
			input logic signed [TORQUE_W-1:0] p, input logic signed [TORQUE_W-1:0] y,
			input logic [DUTY_W-1:0] t);
		in_valid <= 1'b1;
		roll_torque <= r;
		pitch_torque <= p;
		yaw_torque <= y;
		thrust <= t;
		do @(posedge clk); while (in_stall);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// Holds the command side off until every outstanding word has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (words_pending != 0);
		@(posedge clk);
	endtask

	task automatic write_yaw_limit(input logic [DUTY_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [DUTY_W-1:0] limit_value;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset yaw limit.
		send_command(16'sd0, 16'sd0, 16'sd0, 15'd0);
		send_command(16'sd0, 16'sd0, 16'sd0, 15'd16384);
		send_command(16'sd0, 16'sd0, 16'sd0, 15'd8192);
		send_command(16'sd100, -16'sd200, 16'sd50, 15'd8192);
		send_command(16'sd32767, 16'sd32767, 16'sd32767, 15'd8192);
		send_command(-16'sd32768, -16'sd32768, -16'sd32768, 15'd8192);
		send_command(16'sd32767, -16'sd32768, 16'sd0, 15'd16384);
		send_command(-16'sd32768, 16'sd32767, -16'sd32768, 15'd0);
		send_command(16'sd1000, 16'sd1000, 16'sd0, 15'd32767);
		send_command(16'sd0, 16'sd0, 16'sd0, 15'd32767);
		send_command(16'sd0, 16'sd0, 16'sd1311, 15'd8192);
		send_command(16'sd0, 16'sd0, -16'sd1312, 15'd8192);
		send_command(16'sd0, 16'sd0, -16'sd32768, 15'd4000);
		send_command(16'sd16384, 16'sd0, 16'sd0, 15'd16383);
		send_command(-16'sd1, -16'sd1, -16'sd1, 15'd1);
		send_command(16'sd2000, -16'sd3000, 16'sd1000, 15'd6000);
		send_command(16'sd2000, -16'sd3000, 16'sd1001, 15'd6000);
		send_command(16'sd5000, 16'sd5000, -16'sd5000, 15'd12000);

		// A yaw limit above one is held at one.
		wait_drained();
		write_yaw_limit(15'd32767);
		send_command(16'sd0, 16'sd0, 16'sd32767, 15'd8192);
		send_command(16'sd0, 16'sd0, -16'sd32768, 15'd8192);
		send_command(16'sd0, 16'sd0, 16'sd20000, 15'd16384);
		send_command(16'sd3000, -16'sd2000, -16'sd32768, 15'd10000);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: limit_value = 15'd0;
				1: limit_value = 15'd16384;
				2: limit_value = 15'd1;
				4: limit_value = 15'd8192;
				6: limit_value = YAW_LIMIT_RESET;
				default: limit_value = DUTY_W'($urandom_range(0, 32767));
			endcase
			wait_drained();
			write_yaw_limit(limit_value);
			if (ph == PHASES - 1) begin
				calm = 1'b1;
			end
			repeat (PHASE_LEN) begin
				send_command(pick_torque(), pick_torque(), pick_torque(), pick_thrust());
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
src/qtsm_pkg.sv
src/qtsm_prep.sv
src/qtsm_prod.sv
src/qtsm_div_stage.sv
src/qtsm_mix.sv
src/quad_torque_saturate_and_mix.sv
src/qtsm_checker.sv
verif/quad_mix_checker.sv
verif/quad_torque_saturate_and_mix_tb.sv
